// ===== sv/mse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and encodings for the MIPS-subset execute step core.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int MEM_WORDS_DEF = 256;
    localparam int REG_COUNT     = 32;
    localparam int REG_IDX_W     = 5;
    localparam int PC_W          = 10;
    localparam int WORD_W        = 32;

    // Opcodes, bits 31..26 (bit 31 is the valid bit of the encoding)
    localparam logic [5:0] OP_SPECIAL = 6'd32;
    localparam logic [5:0] OP_BLTZ    = 6'd33;
    localparam logic [5:0] OP_J       = 6'd34;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_BEQ     = 6'd36;
    localparam logic [5:0] OP_ADDI    = 6'd40;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] OP_MUL     = 6'd60;

    // Function codes of the special group, bits 5..0
    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_JR    = 6'd8;
    localparam logic [5:0] FN_MOVZ  = 6'd10;
    localparam logic [5:0] FN_BREAK = 6'd13;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;

    typedef struct packed {
        logic                kind;
        logic [PC_W-1:0]     item_address;
        logic [WORD_W-1:0]   item_word;
    } item_t;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic                     halted;
        logic                     dest_written;
        logic [REG_IDX_W-1:0]     dest_index;
        logic signed [WORD_W-1:0] dest_value;
    } result_t;

    // Write-back portion of an executed instruction
    typedef struct packed {
        logic [PC_W-1:0]      next_pc;
        logic                 halted;
        logic                 wr;
        logic [REG_IDX_W-1:0] widx;
        logic [WORD_W-1:0]    wval;
        logic                 is_load;
    } wb_t;

    typedef struct packed {
        wb_t               wb;
        logic              mem_we;
        logic [WORD_W-1:0] mem_addr;
        logic [WORD_W-1:0] mem_wdata;
    } exec_t;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [WORD_W-1:0]    data;
    } rf_wr_t;

    typedef struct packed {
        logic              rd;
        logic              we;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

endpackage

// ===== sv/mse_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_regfile
// 32 x 32 register file, one write and two registered reads per cycle.
// Entries read as zero until first written; a same-cycle write is bypassed.
// ----------------------------------------------------------------------------
module mse_regfile (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [mse_pkg::REG_IDX_W-1:0]    ra,
    input  logic [mse_pkg::REG_IDX_W-1:0]    rb,
    input  mse_pkg::rf_wr_t                  wr,
    output logic [mse_pkg::WORD_W-1:0]       a,
    output logic [mse_pkg::WORD_W-1:0]       b
);

    logic [mse_pkg::WORD_W-1:0]    mem_q [mse_pkg::REG_COUNT];
    logic [mse_pkg::REG_COUNT-1:0] vld_reg;
    logic [mse_pkg::WORD_W-1:0]    a_mem_reg;
    logic [mse_pkg::WORD_W-1:0]    b_mem_reg;
    logic [mse_pkg::WORD_W-1:0]    byp_data_reg;
    logic                          a_hit_reg;
    logic                          b_hit_reg;
    logic                          a_vld_reg;
    logic                          b_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            a_hit_reg <= 1'b0;
            b_hit_reg <= 1'b0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                a_hit_reg <= wr.en && (wr.addr == ra);
                b_hit_reg <= wr.en && (wr.addr == rb);
                a_vld_reg <= vld_reg[ra];
                b_vld_reg <= vld_reg[rb];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_q[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            a_mem_reg    <= mem_q[ra];
            b_mem_reg    <= mem_q[rb];
            byp_data_reg <= wr.data;
        end
    end

    assign a = a_hit_reg ? byp_data_reg : (a_vld_reg ? a_mem_reg : '0);
    assign b = b_hit_reg ? byp_data_reg : (b_vld_reg ? b_mem_reg : '0);

endmodule

// ===== sv/mse_dmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_dmem
// Word-addressed data memory with one write and one registered read port.
// After reset a clearing pass zeroes every word, one word per cycle.
// ----------------------------------------------------------------------------
module mse_dmem #(
    parameter int MEM_WORDS = mse_pkg::MEM_WORDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mse_pkg::mem_req_t          req,
    output logic [mse_pkg::WORD_W-1:0] rdata,
    output logic                       ready
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [mse_pkg::WORD_W-1:0] mem_q [MEM_WORDS];
    logic [mse_pkg::WORD_W-1:0] rdata_reg;
    logic                       clr_busy_reg;
    logic                       clr_busy_next;
    logic [AW-1:0]              clr_idx_reg;
    logic [AW-1:0]              clr_idx_next;
    logic [AW-1:0]              idx;
    logic                       clr_last;

    // Word index: byte address over four, wrapped to the memory size
    assign idx      = req.addr[AW+1:2];
    assign clr_last = (clr_idx_reg == AW'(MEM_WORDS - 1));

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_last)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem_q[clr_idx_reg] <= '0;
        end
        else if (req.we)
        begin
            mem_q[idx] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem_q[idx];
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clr_busy_reg;

endmodule

// ===== sv/mse_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_alu
// Decode and execute of one item: register result, memory request and
// next pc. Purely combinational.
// ----------------------------------------------------------------------------
module mse_alu (
    input  mse_pkg::item_t              item,
    input  logic [mse_pkg::WORD_W-1:0]  a,
    input  logic [mse_pkg::WORD_W-1:0]  b,
    output mse_pkg::exec_t              ex
);

    logic [mse_pkg::WORD_W-1:0]    w;
    logic [5:0]                    op;
    logic [5:0]                    fn;
    logic [mse_pkg::REG_IDX_W-1:0] rt;
    logic [mse_pkg::REG_IDX_W-1:0] rd;
    logic [4:0]                    sa;
    logic [mse_pkg::WORD_W-1:0]    imm_ext;
    logic [mse_pkg::PC_W-1:0]      pc;
    logic [mse_pkg::PC_W-1:0]      pc4;
    logic [mse_pkg::PC_W-1:0]      offs;
    logic                          live;

    assign w       = item.item_word;
    assign op      = w[31:26];
    assign fn      = w[5:0];
    assign rt      = w[20:16];
    assign rd      = w[15:11];
    assign sa      = w[10:6];
    assign imm_ext = {{16{w[15]}}, w[15:0]};
    assign pc      = {item.item_address[mse_pkg::PC_W-1:2], 2'b00};
    assign pc4     = pc + 10'd4;
    // Low eight bits of a word offset or a jump index, times four
    assign offs    = {w[7:0], 2'b00};
    assign live    = w[31] && (w[30:0] != '0);

    always_comb
    begin
        ex              = '0;
        ex.wb.next_pc   = pc4;
        ex.mem_addr     = a + imm_ext;
        ex.mem_wdata    = b;
        if (item.kind)
        begin
            ex.wb.next_pc = item.item_address;
            ex.mem_we     = 1'b1;
            ex.mem_addr   = {22'd0, item.item_address};
            ex.mem_wdata  = w;
        end
        else if (live)
        begin
            case (op)
                mse_pkg::OP_SPECIAL:
                begin
                    case (fn)
                        mse_pkg::FN_ADD:
                        begin
                            ex.wb.wr = 1'b1; ex.wb.widx = rd; ex.wb.wval = a + b;
                        end
                        mse_pkg::FN_SUB:
                        begin
                            ex.wb.wr = 1'b1; ex.wb.widx = rd; ex.wb.wval = a - b;
                        end
                        mse_pkg::FN_AND:
                        begin
                            ex.wb.wr = 1'b1; ex.wb.widx = rd; ex.wb.wval = a & b;
                        end
                        mse_pkg::FN_OR:
                        begin
                            ex.wb.wr = 1'b1; ex.wb.widx = rd; ex.wb.wval = a | b;
                        end
                        mse_pkg::FN_MOVZ:
                        begin
                            if (b == '0)
                            begin
                                ex.wb.wr = 1'b1; ex.wb.widx = rd; ex.wb.wval = a;
                            end
                        end
                        mse_pkg::FN_SLL:
                        begin
                            // all-zero rt, rd and sa is a no-op
                            if ((rt != '0) || (rd != '0) || (sa != '0))
                            begin
                                ex.wb.wr = 1'b1; ex.wb.widx = rd; ex.wb.wval = b << sa;
                            end
                        end
                        mse_pkg::FN_SRL:
                        begin
                            ex.wb.wr = 1'b1; ex.wb.widx = rd; ex.wb.wval = b >> sa;
                        end
                        mse_pkg::FN_JR:
                        begin
                            ex.wb.next_pc = a[mse_pkg::PC_W-1:0];
                        end
                        mse_pkg::FN_BREAK:
                        begin
                            ex.wb.halted = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                mse_pkg::OP_MUL:
                begin
                    ex.wb.wr = 1'b1; ex.wb.widx = rd; ex.wb.wval = a * b;
                end
                mse_pkg::OP_ADDI:
                begin
                    ex.wb.wr = 1'b1; ex.wb.widx = rt; ex.wb.wval = a + imm_ext;
                end
                mse_pkg::OP_LW:
                begin
                    ex.wb.wr = 1'b1; ex.wb.widx = rt; ex.wb.is_load = 1'b1;
                end
                mse_pkg::OP_SW:
                begin
                    ex.mem_we = 1'b1;
                end
                mse_pkg::OP_BEQ:
                begin
                    if (a == b)
                    begin
                        ex.wb.next_pc = pc4 + offs;
                    end
                end
                mse_pkg::OP_BLTZ:
                begin
                    if (a[mse_pkg::WORD_W-1])
                    begin
                        ex.wb.next_pc = pc4 + offs;
                    end
                end
                mse_pkg::OP_J:
                begin
                    ex.wb.next_pc = offs;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sv/mips_subset_execute_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_step_core
// Executes one MIPS-subset instruction, or preloads one data word, per
// transaction and returns the next pc, halt flag and register write.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle when the output is not stalled. In turn,
// the input stage reads the register file, the execute stage accesses the
// data memory, and the result register holds and presents the outcome.
// Register results are forwarded from the memory stage and bypassed at the
// register file read, so dependent instructions issue back to back. After
// reset the data memory is zeroed by a clearing pass over all MEM_WORDS
// words, during which item_ready stays low. MEM_WORDS must be a power of
// two; memory word indexes wrap at MEM_WORDS.
module mips_subset_execute_step_core #(
    parameter int MEM_WORDS = mse_pkg::MEM_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mse_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output mse_pkg::result_t result
);

    logic                       adv_out;
    logic                       adv2;
    logic                       adv1;
    logic                       accept;
    logic                       mem_ready;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    mse_pkg::item_t             s1_item_reg;
    logic                       s2_valid_reg;
    logic                       s2_valid_next;
    mse_pkg::wb_t               s2_reg;
    logic                       result_valid_reg;
    logic                       result_valid_next;
    mse_pkg::result_t           result_reg;

    logic [mse_pkg::WORD_W-1:0] rf_a;
    logic [mse_pkg::WORD_W-1:0] rf_b;
    logic [mse_pkg::WORD_W-1:0] op_a;
    logic [mse_pkg::WORD_W-1:0] op_b;
    logic [mse_pkg::WORD_W-1:0] mem_rdata;
    logic [mse_pkg::WORD_W-1:0] s2_value;
    logic                       fwd_a;
    logic                       fwd_b;
    mse_pkg::exec_t             ex;
    mse_pkg::rf_wr_t            rf_wr;
    mse_pkg::mem_req_t          mem_req;

    assign adv_out    = !result_valid_reg || result_ready;
    assign adv2       = !s2_valid_reg || adv_out;
    assign adv1       = !s1_valid_reg || adv2;
    assign item_ready = adv1 && mem_ready;
    assign accept     = item_valid && item_ready;

    assign s1_valid_next     = adv1 ? accept : s1_valid_reg;
    assign s2_valid_next     = adv2 ? s1_valid_reg : s2_valid_reg;
    assign result_valid_next = adv_out ? s2_valid_reg : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Load data of the item in the memory stage is the registered read
    assign s2_value = s2_reg.is_load ? mem_rdata : s2_reg.wval;

    // Forward the older write still in the memory stage
    assign fwd_a = s2_valid_reg && s2_reg.wr && (s2_reg.widx == s1_item_reg.item_word[25:21]);
    assign fwd_b = s2_valid_reg && s2_reg.wr && (s2_reg.widx == s1_item_reg.item_word[20:16]);
    assign op_a  = fwd_a ? s2_value : rf_a;
    assign op_b  = fwd_b ? s2_value : rf_b;

    assign rf_wr.en   = adv_out && s2_valid_reg && s2_reg.wr;
    assign rf_wr.addr = s2_reg.widx;
    assign rf_wr.data = s2_value;

    assign mem_req.rd    = adv2 && s1_valid_reg;
    assign mem_req.we    = adv2 && s1_valid_reg && ex.mem_we;
    assign mem_req.addr  = ex.mem_addr;
    assign mem_req.wdata = ex.mem_wdata;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_reg <= ex.wb;
        end
        if (adv_out && s2_valid_reg)
        begin
            result_reg.next_pc      <= s2_reg.next_pc;
            result_reg.halted       <= s2_reg.halted;
            result_reg.dest_written <= s2_reg.wr;
            result_reg.dest_index   <= s2_reg.widx;
            result_reg.dest_value   <= $signed(s2_value);
        end
    end

    mse_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .ra    (item.item_word[25:21]),
        .rb    (item.item_word[20:16]),
        .wr    (rf_wr),
        .a     (rf_a),
        .b     (rf_b)
    );

    mse_alu u_alu (
        .item (s1_item_reg),
        .a    (op_a),
        .b    (op_b),
        .ex   (ex)
    );

    mse_dmem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .ready (mem_ready)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sv/mse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the execute step core: no phantom results, in-flight
// bounds, readiness when drained, and output hold under stall.
// ----------------------------------------------------------------------------
module mse_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input mse_pkg::result_t result
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    assign in_acc  = item_valid && item_ready;
    assign out_acc = result_valid && result_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // No result without an accepted transaction behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (cnt_reg != 3'd0))
        else $error("result shown with no transaction in flight");

    // Three pipeline stages bound the transactions in flight
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd3)
        else $error("more than three transactions in flight");

    // Once the clearing pass is over, a drained core takes input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((cnt_reg == 3'd0) && $past(item_ready)) |-> item_ready)
        else $error("drained core not ready");

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind mips_subset_execute_step_core mse_checker u_mse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== test/tb_mips_subset_execute_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_subset_execute_step_core
// Self-checking bench for the MIPS-subset execute step core. A behavioral
// copy of the register file and data memory predicts every result; directed
// instructions, an output stall that backs up the pipeline and a long random
// program with dependent instructions are checked field by field.
// ----------------------------------------------------------------------------
module tb_mips_subset_execute_step_core;

    localparam logic KIND_EXEC    = 1'b0;
    localparam logic KIND_PRELOAD = 1'b1;

    // Encodings outside the subset
    localparam logic [5:0] OP_UNUSED = 6'd63;
    localparam logic [5:0] FN_UNUSED = 6'd63;

    localparam int MEM_WORDS = mse_pkg::MEM_WORDS_DEF;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    mse_pkg::item_t   item_in;
    logic             result_valid;
    logic             result_ready;
    mse_pkg::result_t result_out;

    logic [mse_pkg::WORD_W-1:0] rf_model   [mse_pkg::REG_COUNT];
    logic [mse_pkg::WORD_W-1:0] dmem_model [MEM_WORDS];
    mse_pkg::result_t           expected_results [$];
    mse_pkg::result_t           expected_head;
    logic [mse_pkg::PC_W-1:0]   program_pc;

    bit idle_on;
    int hold_request;
    int n_errors;
    int n_checked;
    int n_exec;
    int n_preload;
    int n_halts;
    int n_writes;

    mips_subset_execute_step_core #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_out)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Instruction encoding
    // ------------------------------------------------------------------------
    function automatic logic [31:0] make_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                           logic [4:0] rd, logic [4:0] sa);
        return {mse_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] make_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Favor a few registers so that back-to-back dependencies are common
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 1) == 0)
            return 5'($urandom_range(0, 3));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] random_instr();
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sa;
        logic [15:0] imm;
        rs  = pick_reg();
        rt  = pick_reg();
        rd  = pick_reg();
        sa  = 5'($urandom_range(0, 31));
        imm = 16'($urandom);
        case ($urandom_range(0, 17))
            0:       return make_r(mse_pkg::FN_ADD, rs, rt, rd, sa);
            1:       return make_r(mse_pkg::FN_SUB, rs, rt, rd, sa);
            2:       return make_r(mse_pkg::FN_AND, rs, rt, rd, sa);
            3:       return make_r(mse_pkg::FN_OR, rs, rt, rd, sa);
            4:       return make_r(mse_pkg::FN_MOVZ, rs, rt, rd, sa);
            5:       return make_r(mse_pkg::FN_SLL, rs, rt, rd, sa);
            6:       return make_r(mse_pkg::FN_SRL, rs, rt, rd, sa);
            7:       return make_r(mse_pkg::FN_JR, rs, rt, rd, sa);
            8:       return make_r(mse_pkg::FN_BREAK, rs, rt, rd, sa);
            9:       return {mse_pkg::OP_MUL, rs, rt, rd, sa, 6'($urandom)};
            10, 11:  return make_i(mse_pkg::OP_ADDI, rs, rt, imm);
            12:      return make_i(mse_pkg::OP_LW, rs, rt, imm);
            13:      return make_i(mse_pkg::OP_SW, rs, rt, imm);
            14:      return make_i(mse_pkg::OP_BEQ, rs, rt, imm);
            15:      return make_i(mse_pkg::OP_BLTZ, rs, rt, imm);
            16:      return {mse_pkg::OP_J, 26'($urandom)};
            default: return make_r(FN_UNUSED, rs, rt, rd, sa);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Behavioral model of one step
    // ------------------------------------------------------------------------
    function automatic int unsigned word_index(logic [31:0] byte_addr);
        return (byte_addr >> 2) % MEM_WORDS;
    endfunction

    function automatic mse_pkg::result_t execute_instruction(mse_pkg::item_t it);
        mse_pkg::result_t         r;
        logic [31:0]              w;
        logic [31:0]              a;
        logic [31:0]              b;
        logic [31:0]              imm;
        logic [31:0]              val;
        logic [31:0]              target;
        logic [mse_pkg::PC_W-1:0] pc;
        logic [5:0]               op;
        logic [5:0]               fn;
        logic [4:0]               rs;
        logic [4:0]               rt;
        logic [4:0]               rd;
        logic [4:0]               sa;
        logic [4:0]               widx;
        logic                     wr;
        w      = it.item_word;
        pc     = {it.item_address[mse_pkg::PC_W-1:2], 2'b00};
        op     = w[31:26];
        fn     = w[5:0];
        rs     = w[25:21];
        rt     = w[20:16];
        rd     = w[15:11];
        sa     = w[10:6];
        imm    = {{16{w[15]}}, w[15:0]};
        a      = rf_model[rs];
        b      = rf_model[rt];
        target = {22'b0, pc} + 32'd4 + (imm << 2);
        wr     = 1'b0;
        widx   = '0;
        val    = '0;
        r      = '0;
        r.next_pc = pc + 10'd4;
        if (it.kind == KIND_PRELOAD)
        begin
            dmem_model[word_index({22'b0, it.item_address})] = w;
            r.next_pc = it.item_address;
        end
        else if (w[31] && w[30:0] != '0)
        begin
            case (op)
                mse_pkg::OP_SPECIAL:
                begin
                    case (fn)
                        mse_pkg::FN_ADD:
                        begin
                            wr = 1'b1; widx = rd; val = a + b;
                        end
                        mse_pkg::FN_SUB:
                        begin
                            wr = 1'b1; widx = rd; val = a - b;
                        end
                        mse_pkg::FN_AND:
                        begin
                            wr = 1'b1; widx = rd; val = a & b;
                        end
                        mse_pkg::FN_OR:
                        begin
                            wr = 1'b1; widx = rd; val = a | b;
                        end
                        mse_pkg::FN_SRL:
                        begin
                            wr = 1'b1; widx = rd; val = b >> sa;
                        end
                        mse_pkg::FN_MOVZ:
                            if (b == '0)
                            begin
                                wr = 1'b1; widx = rd; val = a;
                            end
                        // all-zero shift is the NOP form
                        mse_pkg::FN_SLL:
                            if (rt != '0 || rd != '0 || sa != '0)
                            begin
                                wr = 1'b1; widx = rd; val = b << sa;
                            end
                        mse_pkg::FN_JR:    r.next_pc = a[mse_pkg::PC_W-1:0];
                        mse_pkg::FN_BREAK: r.halted = 1'b1;
                        default:           ;
                    endcase
                end
                mse_pkg::OP_MUL:
                begin
                    wr = 1'b1; widx = rd; val = a * b;
                end
                mse_pkg::OP_ADDI:
                begin
                    wr = 1'b1; widx = rt; val = a + imm;
                end
                mse_pkg::OP_LW:
                begin
                    wr = 1'b1; widx = rt; val = dmem_model[word_index(a + imm)];
                end
                mse_pkg::OP_SW:   dmem_model[word_index(a + imm)] = b;
                mse_pkg::OP_BEQ:  if (a == b) r.next_pc = target[mse_pkg::PC_W-1:0];
                mse_pkg::OP_BLTZ: if (a[31]) r.next_pc = target[mse_pkg::PC_W-1:0];
                mse_pkg::OP_J:    r.next_pc = {w[7:0], 2'b00};
                default:          ;
            endcase
            if (wr)
                rf_model[widx] = val;
        end
        r.dest_written = wr;
        r.dest_index   = widx;
        r.dest_value   = val;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_item(input mse_pkg::item_t it);
        mse_pkg::result_t predicted;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_in    <= it;
        do @(posedge clk); while (!item_ready);
        predicted = execute_instruction(it);
        expected_results.push_back(predicted);
        if (it.kind == KIND_EXEC)
        begin
            program_pc = predicted.next_pc;
            n_exec++;
        end
        else
        begin
            n_preload++;
        end
    endtask

    task automatic send_exec(input logic [mse_pkg::PC_W-1:0] addr, input logic [31:0] word);
        send_item('{kind: KIND_EXEC, item_address: addr, item_word: word});
    endtask

    task automatic send_preload(input logic [mse_pkg::PC_W-1:0] addr,
                                input logic [31:0] word);
        send_item('{kind: KIND_PRELOAD, item_address: addr, item_word: word});
    endtask

    // Drop valid and hold until every predicted result has been seen
    task automatic wait_results_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random short stalls, or one long hold when requested
    // ------------------------------------------------------------------------
    initial
    begin
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                result_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                result_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction: next_pc %0h", result_out.next_pc);
                n_errors++;
            end
            else
            begin
                expected_head = expected_results.pop_front();
                compare_field("next_pc", expected_head.next_pc, result_out.next_pc);
                compare_field("halted", expected_head.halted, result_out.halted);
                compare_field("dest_written", expected_head.dest_written,
                              result_out.dest_written);
                compare_field("dest_index", expected_head.dest_index, result_out.dest_index);
                compare_field("dest_value", expected_head.dest_value, result_out.dest_value);
                n_checked++;
                if (expected_head.halted)
                    n_halts++;
                if (expected_head.dest_written)
                    n_writes++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_ops();
        send_preload(10'h3FF, 32'hFFFF_FFFF);          // unaligned target, kept in next_pc
        send_exec(10'h3FE, make_i(mse_pkg::OP_ADDI, 0, 1, 16'hFFFF));   // pc wraps to zero
        send_exec(program_pc, make_i(mse_pkg::OP_ADDI, 0, 2, 16'h7FFF));
        send_exec(program_pc, make_r(mse_pkg::FN_ADD, 1, 2, 3, 0));
        send_exec(program_pc, make_r(mse_pkg::FN_SUB, 2, 1, 4, 0));
        send_exec(program_pc, make_r(mse_pkg::FN_AND, 1, 2, 5, 0));
        send_exec(program_pc, make_r(mse_pkg::FN_OR, 1, 2, 6, 0));
        send_exec(program_pc, {mse_pkg::OP_MUL, 5'd2, 5'd2, 5'd7, 11'h7FF});
        send_exec(program_pc, make_r(mse_pkg::FN_SLL, 0, 1, 8, 31));
        send_exec(program_pc, make_r(mse_pkg::FN_SRL, 0, 1, 9, 31));
        send_exec(program_pc, make_r(mse_pkg::FN_SLL, 5, 0, 0, 0));    // shift form of NOP
        send_exec(program_pc, 32'h8000_0000);                          // NOP
        send_exec(program_pc, 32'h7FFF_FFFF);                          // valid bit clear
        send_exec(program_pc, make_r(mse_pkg::FN_MOVZ, 2, 0, 10, 0));  // r0 still zero: write
        send_exec(program_pc, make_r(mse_pkg::FN_MOVZ, 2, 1, 11, 0));  // rt nonzero: no write
        send_exec(program_pc, make_i(mse_pkg::OP_SW, 0, 2, 16'h0008));
        send_exec(program_pc, make_i(mse_pkg::OP_LW, 0, 12, 16'h0008));
        send_exec(program_pc, make_i(mse_pkg::OP_LW, 1, 13, 16'h0000)); // negative address wraps
        send_exec(program_pc, make_i(mse_pkg::OP_ADDI, 1, 0, 16'h0005)); // r0 is writable
        send_exec(program_pc, make_i(mse_pkg::OP_BEQ, 1, 1, 16'hFFFF));
        send_exec(program_pc, make_i(mse_pkg::OP_BEQ, 1, 2, 16'h0010));
        send_exec(10'h3FC, make_i(mse_pkg::OP_BLTZ, 1, 0, 16'h7FFF));
        send_exec(program_pc, make_i(mse_pkg::OP_BLTZ, 2, 0, 16'h8000));
        send_exec(program_pc, {mse_pkg::OP_J, 26'h3FF_FFFF});
        send_exec(program_pc, make_r(mse_pkg::FN_JR, 1, 0, 0, 0));
        send_exec(program_pc, make_r(mse_pkg::FN_BREAK, 0, 0, 0, 0));
        send_exec(program_pc, make_i(OP_UNUSED, 1, 2, 16'hFFFF));
        send_exec(program_pc, make_r(FN_UNUSED, 1, 2, 3, 4));
    endtask

    // Stall the output long enough that the core must push back on its input
    task automatic test_output_backpressure();
        int i;
        hold_request = 64;
        for (i = 0; i < 40; i++)
        begin
            if (i % 2 == 0)
                send_exec(program_pc, make_i(mse_pkg::OP_ADDI, 1, 1, 16'h0001));
            else
                send_exec(program_pc, random_instr());
        end
    endtask

    task automatic test_random_program(input int count);
        int          i;
        int          sel;
        logic [31:0] w;
        logic [9:0]  addr;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
            begin
                send_preload(10'($urandom_range(0, 1023)), $urandom);
            end
            else if (sel == 1)
            begin
                send_exec(10'($urandom_range(0, 1023)), $urandom);
            end
            else
            begin
                w    = random_instr();
                addr = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023)) : program_pc;
                send_exec(addr, w);
                // read back the word just stored, with the load right behind the store
                if (w[31:26] == mse_pkg::OP_SW)
                    send_exec(program_pc,
                              make_i(mse_pkg::OP_LW, w[25:21], pick_reg(), w[15:0]));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item_in      <= '0;
        idle_on      = 1'b1;
        hold_request = 0;
        program_pc   = '0;
        foreach (rf_model[i])
            rf_model[i] = '0;
        foreach (dmem_model[i])
            dmem_model[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        wait_results_drained();
        test_output_backpressure();
        wait_results_drained();
        test_random_program(1700);
        idle_on = 1'b0;
        test_random_program(300);
        wait_results_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d instructions and %0d preloads, %0d results checked",
                 n_exec, n_preload, n_checked);
        $display("(%0d register writes, %0d breaks), with stalls on both sides.",
                 n_writes, n_halts);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mse_pkg.sv
sv/mse_regfile.sv
sv/mse_dmem.sv
sv/mse_alu.sv
sv/mips_subset_execute_step_core.sv
sv/mse_checker.sv
test/tb_mips_subset_execute_step_core.sv
